[hdl/cda_pkg.sv]
// Shared types, constants and calendar functions for the calendar date adder.
`default_nettype none

package cda_pkg;

  localparam int YEAR_BITS_DEF   = 16;
  localparam int AMOUNT_BITS_DEF = 16;

  localparam int MONTH_W         = 4;
  localparam int DAY_W           = 5;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int LEAP_CYCLE      = 400;
  localparam int MOD_W           = $clog2(LEAP_CYCLE);

  typedef enum logic [1:0] {
    OP_SET        = 2'd0,
    OP_ADD_DAYS   = 2'd1,
    OP_ADD_MONTHS = 2'd2,
    OP_ADD_YEARS  = 2'd3
  } op_t;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  localparam logic [DAY_W-1:0] DAY_FIRST = DAY_W'(1);
  localparam logic [DAY_W-1:0] DAYS_FEB  = DAY_W'(28);
  localparam logic [DAY_W-1:0] DAYS_FEB_LEAP = DAY_W'(29);
  localparam logic [DAY_W-1:0] DAYS_30   = DAY_W'(30);
  localparam logic [DAY_W-1:0] DAYS_31   = DAY_W'(31);

  localparam logic [MOD_W-1:0] CENTURY_1 = MOD_W'(100);
  localparam logic [MOD_W-1:0] CENTURY_2 = MOD_W'(200);
  localparam logic [MOD_W-1:0] CENTURY_3 = MOD_W'(300);
  localparam logic [MOD_W-1:0] MOD_LAST  = MOD_W'(LEAP_CYCLE - 1);

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic load_mod;
    logic apply_months;
    logic day_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic days_done;
  } sts_t;

  // leap test from year mod 400: multiple of 4 but not a plain century
  function automatic logic is_leap(input logic [MOD_W-1:0] ymod);
    is_leap = (ymod[1:0] == 2'b00) && (ymod != CENTURY_1) &&
              (ymod != CENTURY_2) && (ymod != CENTURY_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    case (month)
      MONTH_FEB: month_days = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_days = DAYS_30;
      default: month_days = DAYS_31;
    endcase
  endfunction

endpackage

`default_nettype wire

[hdl/cda_if.sv]
// Request and response channel interfaces of the calendar date adder.
`default_nettype none

interface cda_req_if #(
  parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF,
  parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  cda_pkg::op_t                 opcode;
  logic [YEAR_BITS-1:0]         set_year;
  logic [cda_pkg::MONTH_W-1:0]  set_month;
  logic [cda_pkg::DAY_W-1:0]    set_day;
  logic [AMOUNT_BITS-1:0]       amount;

  modport source (output valid, opcode, set_year, set_month, set_day, amount,
                  input ready);
  modport sink   (input valid, opcode, set_year, set_month, set_day, amount,
                  output ready);
endinterface

interface cda_rsp_if #(
  parameter int YEAR_BITS = cda_pkg::YEAR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [YEAR_BITS-1:0]         cur_year;
  logic [cda_pkg::MONTH_W-1:0]  cur_month;
  logic [cda_pkg::DAY_W-1:0]    cur_day;
  logic                         year_overflow;

  modport source (output valid, cur_year, cur_month, cur_day, year_overflow,
                  input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, year_overflow,
                  output ready);
endinterface

`default_nettype wire

[hdl/cda_cdiv.sv]
// Divider by a constant: reciprocal multiply, then quotient and remainder.
`default_nettype none

module cda_cdiv #(
  parameter int WIDTH   = 17,
  parameter int DIVISOR = 12,
  localparam int REM_W  = $clog2(DIVISOR)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  output logic             busy,
  output logic [WIDTH-1:0] quotient,
  output logic [REM_W-1:0] remainder
);

  // floor(x * RECIP / 2^SHIFT) equals floor(x / DIVISOR) for every WIDTH-bit x
  localparam int SHIFT   = WIDTH + REM_W;
  localparam int RECIP_W = WIDTH + 2;
  localparam int PROD_W  = WIDTH + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
  localparam logic [WIDTH-1:0] DIV_VAL = WIDTH'(DIVISOR);

  logic [1:0]        phase;
  logic [WIDTH-1:0]  x;
  logic [PROD_W-1:0] prod;
  logic [WIDTH-1:0]  q_est;
  logic [WIDTH-1:0]  back;
  logic [WIDTH-1:0]  diff;
  logic [WIDTH-1:0]  quo;
  logic [REM_W-1:0]  rem;

  assign busy  = phase != 2'b00;
  assign q_est = WIDTH'(prod[PROD_W-1:SHIFT]);
  assign back  = q_est * DIV_VAL;
  assign diff  = x - back;

  // phase 01: multiply by the reciprocal, phase 10: quotient and remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'b00;
    end else if (start) begin
      phase <= 2'b01;
    end else begin
      phase <= {phase[0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= dividend;
    end
    if (phase[0]) begin
      prod <= PROD_W'(x) * PROD_W'(RECIP);
    end
    if (phase[1]) begin
      quo <= q_est;
      rem <= diff[REM_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

[hdl/cda_dp.sv]
// Datapath of the calendar date adder: date registers, year adder, dividers.
`default_nettype none

module cda_dp #(
  parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF,
  parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cda_pkg::cmd_t               cmd,
  output cda_pkg::sts_t               sts,
  input  cda_pkg::op_t                opcode,
  input  logic [YEAR_BITS-1:0]        set_year,
  input  logic [cda_pkg::MONTH_W-1:0] set_month,
  input  logic [cda_pkg::DAY_W-1:0]   set_day,
  input  logic [AMOUNT_BITS-1:0]      amount,
  output logic [YEAR_BITS-1:0]        cur_year,
  output logic [cda_pkg::MONTH_W-1:0] cur_month,
  output logic [cda_pkg::DAY_W-1:0]   cur_day,
  output logic                        year_overflow
);

  localparam int QW    = AMOUNT_BITS + 1;
  localparam int NW    = AMOUNT_BITS + 1;
  localparam int SUM_W = ((YEAR_BITS > QW) ? YEAR_BITS : QW) + 1;
  localparam int MW    = cda_pkg::MONTH_W;
  localparam int DW    = cda_pkg::DAY_W;
  localparam int RW12  = $clog2(cda_pkg::MONTHS_PER_YEAR);

  logic [YEAR_BITS-1:0]       year;
  logic [MW-1:0]              month;
  logic [DW-1:0]              day;
  logic                       ovf;
  logic [NW-1:0]              n;
  logic [cda_pkg::MOD_W-1:0]  ymod;

  logic                       busy12;
  logic                       busy400;
  logic [QW-1:0]              q12;
  logic [RW12-1:0]            rem12;
  logic [cda_pkg::MOD_W-1:0]  rem400;

  logic [QW-1:0]              addend;
  logic [SUM_W-1:0]           year_sum;
  logic [YEAR_BITS-1:0]       new_year;
  logic                       wrap;

  logic                       leap;
  logic [DW-1:0]              len;
  logic [NW:0]                day_sum;
  logic                       exceeds;
  logic                       roll;
  logic                       is_dec;
  logic [MW-1:0]              clamp_month;

  cda_cdiv #(
    .WIDTH   (QW),
    .DIVISOR (cda_pkg::MONTHS_PER_YEAR)
  ) u_div12 (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.capture && (opcode == cda_pkg::OP_ADD_MONTHS)),
    .dividend  (QW'(month) + QW'(amount)),
    .busy      (busy12),
    .quotient  (q12),
    .remainder (rem12)
  );

  // year mod 400 for the leap rule, refreshed at the start of each add-days
  cda_cdiv #(
    .WIDTH   (YEAR_BITS),
    .DIVISOR (cda_pkg::LEAP_CYCLE)
  ) u_div400 (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.capture && (opcode == cda_pkg::OP_ADD_DAYS)),
    .dividend  (year),
    .busy      (busy400),
    .quotient  (),
    .remainder (rem400)
  );

  assign leap    = cda_pkg::is_leap(ymod);
  assign len     = cda_pkg::month_days(month, leap);
  assign day_sum = (NW + 1)'(day) + (NW + 1)'(n);
  assign exceeds = day_sum > (NW + 1)'(len);
  assign roll    = cmd.day_step && (n != '0) && exceeds;
  assign is_dec  = month == cda_pkg::MONTH_DEC;

  assign sts.div_busy  = busy12 | busy400;
  assign sts.days_done = (n == '0) || !exceeds;

  // one shared year adder
  always_comb begin
    if (cmd.capture) begin
      addend = QW'(amount);
    end else if (cmd.apply_months) begin
      addend = (rem12 != '0) ? q12 : q12 - 1'b1;
    end else if (roll) begin
      addend = QW'(1);
    end else begin
      addend = '0;
    end
  end

  assign year_sum = SUM_W'(year) + SUM_W'(addend);
  assign new_year = year_sum[YEAR_BITS-1:0];
  assign wrap     = |year_sum[SUM_W-1:YEAR_BITS];

  always_comb begin
    if (set_month == '0) begin
      clamp_month = cda_pkg::MONTH_JAN;
    end else if (set_month > cda_pkg::MONTH_DEC) begin
      clamp_month = cda_pkg::MONTH_DEC;
    end else begin
      clamp_month = set_month;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year  <= '0;
      month <= cda_pkg::MONTH_JAN;
      day   <= cda_pkg::DAY_FIRST;
      ovf   <= 1'b0;
    end else if (cmd.capture) begin
      case (opcode)
        cda_pkg::OP_SET: begin
          year  <= set_year;
          month <= clamp_month;
          day   <= set_day;
          ovf   <= 1'b0;
        end
        cda_pkg::OP_ADD_YEARS: begin
          year <= new_year;
          ovf  <= wrap;
        end
        default: begin
          ovf <= 1'b0;
        end
      endcase
    end else if (cmd.apply_months) begin
      year  <= new_year;
      ovf   <= wrap;
      month <= (rem12 != '0) ? MW'(rem12) : cda_pkg::MONTH_DEC;
    end else if (cmd.day_step && (n != '0)) begin
      if (exceeds) begin
        // day 0 stands for the last day of the previous month
        day <= '0;
        if (is_dec) begin
          month <= cda_pkg::MONTH_JAN;
          year  <= new_year;
          if (wrap) begin
            ovf <= 1'b1;
          end
        end else begin
          month <= month + 1'b1;
        end
      end else begin
        day <= day_sum[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      n <= NW'(amount);
    end else if (roll) begin
      n <= NW'(day_sum - (NW + 1)'(len));
    end
    if (cmd.load_mod) begin
      ymod <= rem400;
    end else if (roll && is_dec) begin
      // a wrapped year is 0, which is a multiple of 400
      ymod <= (wrap || (ymod == cda_pkg::MOD_LAST)) ? '0 : ymod + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cur_year      <= year;
      cur_month     <= month;
      cur_day       <= day;
      year_overflow <= ovf;
    end
  end

endmodule

`default_nettype wire

[hdl/cda_ctrl.sv]
// Controller of the calendar date adder: sequences one request at a time.
`default_nettype none

module cda_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  cda_pkg::op_t  req_opcode,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cda_pkg::cmd_t cmd,
  input  cda_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_DAYS   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t       state;
  state_t       state_next;
  cda_pkg::op_t op;

  assign req_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          case (req_opcode)
            cda_pkg::OP_ADD_DAYS, cda_pkg::OP_ADD_MONTHS: state_next = S_DIV;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          if (op == cda_pkg::OP_ADD_DAYS) begin
            cmd.load_mod = 1'b1;
            state_next   = S_DAYS;
          end else begin
            cmd.apply_months = 1'b1;
            state_next       = S_FINISH;
          end
        end
      end
      S_DAYS: begin
        // one month crossed per cycle; last step adds the leftover days
        cmd.day_step = 1'b1;
        if (sts.days_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= req_opcode;
    end
  end

endmodule

`default_nettype wire

[hdl/calendar_date_adder.sv]
// Top level of the calendar date adder: Gregorian date register with add operations.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------
//   req     | in  | opcode, set_year, set_month, set_day, amount
//   rsp     | out | cur_year, cur_month, cur_day, year_overflow
//
// One request at a time. Set and add years need no divide. Add months first runs
// a reciprocal divide by 12. Add days first divides the year by 400 for the leap
// rule, then walks the date one month at a time. Reset gives year 0, January 1st.
// The response sits in its own register, so the next request is taken while
// an earlier response is still stalled; completion waits only if it is still full.
`default_nettype none

module calendar_date_adder #(
  parameter int YEAR_BITS   = cda_pkg::YEAR_BITS_DEF,
  parameter int AMOUNT_BITS = cda_pkg::AMOUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  cda_req_if.sink       req,
  cda_rsp_if.source     rsp
);

  cda_pkg::cmd_t cmd;
  cda_pkg::sts_t sts;

  cda_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  cda_dp #(
    .YEAR_BITS   (YEAR_BITS),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (req.opcode),
    .set_year      (req.set_year),
    .set_month     (req.set_month),
    .set_day       (req.set_day),
    .amount        (req.amount),
    .cur_year      (rsp.cur_year),
    .cur_month     (rsp.cur_month),
    .cur_day       (rsp.cur_day),
    .year_overflow (rsp.year_overflow)
  );

endmodule

`default_nettype wire

[verif/calendar_date_adder_tb.sv]
// Self-checking testbench for calendar_date_adder: directed table, then random requests.
`default_nettype none

module calendar_date_adder_tb;

  localparam int          N_RAND    = 250;
  localparam int          LONG_HOLD = 400;
  localparam int unsigned LIMIT     = 3_000_000;

  localparam int YW = cda_pkg::YEAR_BITS_DEF;
  localparam int AW = cda_pkg::AMOUNT_BITS_DEF;
  localparam int MW = cda_pkg::MONTH_W;
  localparam int DW = cda_pkg::DAY_W;

  typedef struct packed {
    cda_pkg::op_t  opcode;
    logic [YW-1:0] set_year;
    logic [MW-1:0] set_month;
    logic [DW-1:0] set_day;
    logic [AW-1:0] amount;
  } date_req_t;

  typedef struct packed {
    logic [YW-1:0] year;
    logic [MW-1:0] month;
    logic [DW-1:0] day;
    logic          ovf;
  } date_t;

  typedef struct {
    date_req_t rq;
    bit        typed;
    date_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cda_req_if req_ch ();
  cda_rsp_if rsp_ch ();

  calendar_date_adder u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // predicted calendar state
  logic [YW-1:0] cal_year  = '0;
  logic [MW-1:0] cal_month = MW'(1);
  logic [DW-1:0] cal_day   = DW'(1);
  logic          cal_wrap  = 1'b0;

  date_t       dates_due[$];
  dir_row_t    dir_tab[$];
  date_t       due;
  int          n_err      = 0;
  int          burst_left = 0;
  int          hold_reqs  = 0;
  int unsigned cycles     = 0;

  function automatic bit cal_leap();
    int unsigned y;
    y = 32'(cal_year);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400 == 0);
  endfunction

  function automatic int unsigned cal_month_len();
    case (cal_month)
      4'd2: return cal_leap() ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic void cal_add_years(input int unsigned n);
    int unsigned y;
    y = 32'(cal_year) + n;
    if (y > 32'hFFFF) cal_wrap = 1'b1;
    cal_year = y[YW-1:0];
  endfunction

  function automatic void cal_add_months(input int unsigned n);
    int unsigned t;
    t = 32'(cal_month) + n;
    if (t % 12 != 0) begin
      cal_add_years(t / 12);
      cal_month = MW'(t % 12);
    end else begin
      cal_add_years(t / 12 - 1);
      cal_month = MW'(12);
    end
  endfunction

  // walk one month at a time; a day past the month length carries forward
  function automatic void cal_add_days(input int unsigned n);
    int unsigned len;
    while (n != 0) begin
      len = cal_month_len();
      if (32'(cal_day) + n > len) begin
        n = n + 32'(cal_day) - len;
        cal_add_months(1);
        cal_day = '0;
      end else begin
        cal_day = DW'(32'(cal_day) + n);
        n = 0;
      end
    end
  endfunction

  function automatic date_t cal_apply(input date_req_t r);
    date_t res;
    cal_wrap = 1'b0;
    case (r.opcode)
      cda_pkg::OP_SET: begin
        cal_year = r.set_year;
        if (r.set_month == 0) cal_month = MW'(1);
        else if (r.set_month > 12) cal_month = MW'(12);
        else cal_month = r.set_month;
        cal_day = r.set_day;
      end
      cda_pkg::OP_ADD_DAYS:   cal_add_days(32'(r.amount));
      cda_pkg::OP_ADD_MONTHS: cal_add_months(32'(r.amount));
      default:                cal_add_years(32'(r.amount));
    endcase
    res.year  = cal_year;
    res.month = cal_month;
    res.day   = cal_day;
    res.ovf   = cal_wrap;
    return res;
  endfunction

  function automatic date_req_t rand_req();
    date_req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.opcode    = cda_pkg::OP_SET;
    r.set_year  = 16'($urandom);
    r.set_month = 4'($urandom);
    r.set_day   = 5'($urandom);
    r.amount    = 16'($urandom);
    if (k < 25) begin
      case ($urandom_range(0, 3))
        0: r.set_year = 16'($urandom_range(65500, 65535));
        1: r.set_year = 16'($urandom_range(0, 655) * 100 + $urandom_range(0, 4));
        default: ;
      endcase
    end else if (k < 60) begin
      r.opcode = cda_pkg::OP_ADD_DAYS;
      case ($urandom_range(0, 9))
        0: ;
        1, 2: r.amount = 16'($urandom_range(0, 2000));
        3: r.amount = '0;
        default: r.amount = 16'($urandom_range(0, 400));
      endcase
    end else if (k < 80) begin
      r.opcode = cda_pkg::OP_ADD_MONTHS;
      if ($urandom_range(0, 3) != 0) r.amount = 16'($urandom_range(0, 40));
    end else begin
      r.opcode = cda_pkg::OP_ADD_YEARS;
      if ($urandom_range(0, 4) != 0) r.amount = 16'($urandom_range(0, 600));
    end
    return r;
  endfunction

  task automatic add_row(input cda_pkg::op_t op, input int y, input int m, input int d,
                         input int amt, input bit typed = 1'b0, input int wy = 0,
                         input int wm = 0, input int wd = 0, input int wo = 0);
    dir_row_t row;
    row.rq.opcode    = op;
    row.rq.set_year  = 16'(y);
    row.rq.set_month = 4'(m);
    row.rq.set_day   = 5'(d);
    row.rq.amount    = 16'(amt);
    row.typed        = typed;
    row.want.year    = 16'(wy);
    row.want.month   = 4'(wm);
    row.want.day     = 5'(wd);
    row.want.ovf     = 1'(wo);
    dir_tab.push_back(row);
  endtask

  task automatic offer(input date_req_t r, input bit typed, input date_t want);
    date_t got;
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= r.opcode;
    req_ch.set_year  <= r.set_year;
    req_ch.set_month <= r.set_month;
    req_ch.set_day   <= r.set_day;
    req_ch.amount    <= r.amount;
    do @(posedge clk); while (!req_ch.ready);
    got = cal_apply(r);
    dates_due.push_back(typed ? want : got);
  endtask

  // sender bursts and gaps
  task automatic pace();
    int gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 5) == 0) gap = $urandom_range(20, 60);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (dates_due.size() != 0);
  endtask

  // stimulus
  initial begin
    date_req_t r;
    req_ch.valid     <= 1'b0;
    req_ch.opcode    <= cda_pkg::OP_SET;
    req_ch.set_year  <= '0;
    req_ch.set_month <= '0;
    req_ch.set_day   <= '0;
    req_ch.amount    <= '0;

    add_row(cda_pkg::OP_ADD_YEARS,  0,     0,  0,  0,     1'b1, 0,     1,  1,  0);
    add_row(cda_pkg::OP_SET,        65535, 12, 31, 0,     1'b1, 65535, 12, 31, 0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  1,     1'b1, 0,     1,  1,  1);
    add_row(cda_pkg::OP_SET,        2000,  2,  28, 0,     1'b1, 2000,  2,  28, 0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  1,     1'b1, 2000,  2,  29, 0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  1);
    add_row(cda_pkg::OP_SET,        1900,  2,  28, 0,     1'b1, 1900,  2,  28, 0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  1);
    add_row(cda_pkg::OP_SET,        2024,  2,  29, 0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  366);
    // day past month end on set carries on the next add
    add_row(cda_pkg::OP_SET,        2023,  4,  31, 0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  1);
    add_row(cda_pkg::OP_SET,        10,    0,  0,  65535, 1'b1, 10,    1,  0,  0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  1);
    add_row(cda_pkg::OP_SET,        7,     15, 31, 0,     1'b1, 7,     12, 31, 0);
    add_row(cda_pkg::OP_ADD_MONTHS, 0,     0,  0,  0,     1'b1, 7,     12, 31, 0);
    add_row(cda_pkg::OP_ADD_MONTHS, 0,     0,  0,  12);
    add_row(cda_pkg::OP_SET,        2023,  1,  31, 0);
    add_row(cda_pkg::OP_ADD_MONTHS, 0,     0,  0,  1);
    add_row(cda_pkg::OP_ADD_MONTHS, 0,     0,  0,  65535);
    add_row(cda_pkg::OP_SET,        65530, 6,  15, 0);
    add_row(cda_pkg::OP_ADD_YEARS,  0,     0,  0,  10,    1'b1, 4,     6,  15, 1);
    add_row(cda_pkg::OP_ADD_YEARS,  0,     0,  0,  65535);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  0);
    add_row(cda_pkg::OP_SET,        0,     1,  1,  0);
    add_row(cda_pkg::OP_ADD_DAYS,   0,     0,  0,  65535);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      offer(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
      pace();
    end
    settle();

    for (int i = 0; i < N_RAND; i++) begin
      // receiver holds off while requests keep coming, so the input backs up
      if (i == N_RAND / 3) begin
        hold_reqs  <= hold_reqs + 1;
        burst_left = 10;
      end
      if (i == 2 * N_RAND / 3) settle();
      r = rand_req();
      offer(r, 1'b0, '0);
      pace();
    end

    settle();
    repeat (100) @(posedge clk);
    if (n_err == 0) begin
      $display("calendar_date_adder_tb OK");
    end else begin
      $display("calendar_date_adder_tb NOT OK");
    end
    $finish;
  end

  // receiver stall pattern
  initial begin
    int mode;
    int seg_left;
    int holds_done;
    mode       = 0;
    seg_left   = 0;
    holds_done = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (dates_due.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("unexpected response: %0d-%0d-%0d ovf %0d", rsp_ch.cur_year,
                   rsp_ch.cur_month, rsp_ch.cur_day, rsp_ch.year_overflow);
      end else begin
        due = dates_due.pop_front();
        if (rsp_ch.cur_year !== due.year || rsp_ch.cur_month !== due.month ||
            rsp_ch.cur_day !== due.day || rsp_ch.year_overflow !== due.ovf) begin
          n_err++;
          if (n_err <= 10)
            $display("date mismatch: want %0d-%0d-%0d ovf %0d, got %0d-%0d-%0d ovf %0d",
                     due.year, due.month, due.day, due.ovf, rsp_ch.cur_year,
                     rsp_ch.cur_month, rsp_ch.cur_day, rsp_ch.year_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("calendar_date_adder_tb NOT OK");
      $finish;
    end
  end

endmodule

`default_nettype wire
